[hw/rtl/dscd_pkg.sv]
// ----------------------------------------------------------------------------
// dscd_pkg
// shared types, constants and control words for the dual stick calibration
// and radial deadzone block
// ----------------------------------------------------------------------------
package dscd_pkg;

    // default number of frames averaged for the stick centers
    localparam int CAL_FRAMES_DEF = 50;

    localparam int RAW_W   = 8;
    localparam int OUT_W   = 16;
    localparam int SUM_W   = 14;
    localparam int NUM_W   = 23;   // diff * full scale
    localparam int QUO_W   = 15;   // quotient bits before saturation
    localparam int MAG_W   = 15;   // magnitude of a scaled axis
    localparam int SQ_W    = 2 * MAG_W;
    localparam int N_AXIS  = 4;
    localparam int AXIS_W  = 2;
    localparam int CFG_IDX_W = 4;

    localparam logic [RAW_W-1:0]     FRAME_HEAD   = 8'hFF;
    localparam logic [RAW_W-1:0]     FRAME_TAIL   = 8'hFE;
    localparam logic [RAW_W-1:0]     CENTER_RESET = 8'd130;
    localparam logic [RAW_W-1:0]     MIN_RESET    = 8'd85;
    localparam logic [RAW_W-1:0]     MAX_RESET    = 8'd200;
    localparam logic [MAG_W-1:0]     AXIS_FULL    = 15'd32760;
    localparam logic [SQ_W:0]        DEAD_R2      = 31'd10732176;  // 3276 squared
    localparam logic [CFG_IDX_W-1:0] CFG_NREG     = 4'd8;

    // input word, fields in frame order
    typedef struct packed {
        logic [RAW_W-1:0] start_byte;
        logic [RAW_W-1:0] left_y_raw;
        logic [RAW_W-1:0] left_x_raw;
        logic [RAW_W-1:0] right_y_raw;
        logic [RAW_W-1:0] right_x_raw;
        logic [RAW_W-1:0] end_byte;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] left_y;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_y;
    } out_word_t;

    // per axis calibration limits
    typedef struct packed {
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
    } lim_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CAL_STORE,
        S_SCL_LOAD,
        S_SCL_DIV,
        S_SCL_STORE,
        S_SQ,
        S_ACC,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_frame;
        logic accum;
        logic div_load_scl;
        logic div_step;
        logic store_center;
        logic store_axis;
        logic axis_clr;
        logic axis_inc;
        logic sq;
        logic acc;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_ok;
        logic calibrating;
        logic cal_last;
        logic div_done;
        logic axis_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

[hw/rtl/dual_stick_calibrate_deadzone_top.sv]
// path: a valid frame after calibration runs through the frame check, the
//   scaling of 4 axes on the 15-step divider, the radius check and the
//   load of the output register, which waits while a stalled word is held
// input: a new frame is taken only once the one before is done; invalid and
//   calibration frames skip scaling, the final calibration frame stores centers
// reset: synchronous active-low aresetn restores limits, centers, sums and
//   the frame count at once, no clearing pass
// ----------------------------------------------------------------------------
// dual_stick_calibrate_deadzone_top
// two stick calibration with piecewise axis scaling and radial deadzone
// ----------------------------------------------------------------------------
module dual_stick_calibrate_deadzone_top
    import dscd_pkg::*;
#(
    parameter int CAL_FRAMES = CAL_FRAMES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    dscd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dscd_datapath #(
        .CAL_FRAMES (CAL_FRAMES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[hw/rtl/dscd_div.sv]
// ----------------------------------------------------------------------------
// dscd_div
// restoring divider, one quotient bit per cycle while step is held high;
// the dividend must be below the divisor shifted up by the quotient width
// ----------------------------------------------------------------------------
module dscd_div
    import dscd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             step,
    input  logic [NUM_W-1:0] num,
    input  logic [RAW_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fits;

    // one trial subtract per step
    always_comb begin
        fits     = rem_reg >= dsh_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (load) begin
            rem_next = num;
            dsh_next = NUM_W'({den, {(QUO_W-1){1'b0}}});
            quo_next = '0;
            cnt_next = CNT_W'(QUO_W);
        end else if (step && cnt_reg != '0) begin
            rem_next = fits ? rem_reg - dsh_reg : rem_reg;
            dsh_next = dsh_reg >> 1;
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = cnt_reg == '0;

endmodule

[hw/rtl/dscd_datapath.sv]
// ----------------------------------------------------------------------------
// dscd_datapath
// frame register, limits, centers and sums, per axis scaling through the
// serial divider, squared radius check and the result register
// ----------------------------------------------------------------------------
module dscd_datapath
    import dscd_pkg::*;
#(
    parameter int CAL_FRAMES = CAL_FRAMES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output ctrl_sts_t            sts,
    input  in_word_t             s_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);

    localparam int CNT_W = $clog2(CAL_FRAMES + 1);

    // reciprocal of the frame count, exact for every sum below 2^SUM_W
    localparam int RECIP_SH = SUM_W + $clog2(CAL_FRAMES);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH + CAL_FRAMES - 1) / CAL_FRAMES);

    in_word_t                 frame_reg;
    lim_t                     lim_reg    [N_AXIS];
    logic [RAW_W-1:0]         center_reg [N_AXIS];
    logic [SUM_W-1:0]         sum_reg    [N_AXIS];
    logic [CNT_W-1:0]         count_reg;
    logic [AXIS_W-1:0]        axis_reg;
    logic signed [OUT_W-1:0]  ax_reg     [N_AXIS];
    logic                     zero_reg, sat_reg, neg_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          mag_reg;
    logic                     m_valid_reg;
    out_word_t                m_data_reg;

    logic [RAW_W-1:0]         raw_ax     [N_AXIS];
    logic [RAW_W-1:0]         raw_sel, c_sel;
    lim_t                     lim_sel;
    logic                     gt, lt;
    logic [RAW_W-1:0]         diff;
    logic [RAW_W:0]           span9, span_neg9;
    logic [RAW_W-1:0]         span_mag;
    logic [NUM_W-1:0]         num_scl;
    logic                     sat_now, zero_now, neg_now;
    logic [PROD_W-1:0]        cal_prod;
    logic [QUO_W-1:0]         quo;
    logic                     div_done;
    logic [MAG_W-1:0]         mag_clip;
    logic signed [OUT_W-1:0]  ax_val;
    logic signed [OUT_W-1:0]  ax_cur, ax_neg;
    logic [MAG_W-1:0]         ax_abs;
    logic [SQ_W:0]            rad2;
    logic                     in_dead;

    // axis order: left x, left y, right x, right y
    assign raw_ax[0] = frame_reg.left_x_raw;
    assign raw_ax[1] = frame_reg.left_y_raw;
    assign raw_ax[2] = frame_reg.right_x_raw;
    assign raw_ax[3] = frame_reg.right_y_raw;

    // operands of the current axis
    always_comb begin
        raw_sel   = raw_ax[axis_reg];
        c_sel     = center_reg[axis_reg];
        lim_sel   = lim_reg[axis_reg];
        gt        = raw_sel > c_sel;
        lt        = raw_sel < c_sel;
        diff      = gt ? raw_sel - c_sel : c_sel - raw_sel;
        span9     = gt ? {1'b0, lim_sel.hi} - {1'b0, c_sel}
                       : {1'b0, c_sel} - {1'b0, lim_sel.lo};
        span_neg9 = -span9;
        span_mag  = span9[RAW_W] ? span_neg9[RAW_W-1:0] : span9[RAW_W-1:0];
        num_scl   = NUM_W'(diff) * NUM_W'(AXIS_FULL);
        sat_now   = num_scl >= NUM_W'({span_mag, {QUO_W{1'b0}}});
        zero_now  = !(gt || lt) || span_mag == '0;
        neg_now   = lt ^ span9[RAW_W];
    end

    // center average by reciprocal multiply
    always_comb begin
        cal_prod = PROD_W'(sum_reg[axis_reg]) * PROD_W'(RECIP);
    end

    dscd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.div_load_scl),
        .step    (cmd.div_step),
        .num     (num_scl),
        .den     (span_mag),
        .quo     (quo),
        .done    (div_done)
    );

    // saturate and apply sign
    always_comb begin
        mag_clip = (sat_reg || quo > AXIS_FULL) ? AXIS_FULL : quo;
        if (zero_reg) begin
            ax_val = '0;
        end else if (neg_reg) begin
            ax_val = -$signed({1'b0, mag_clip});
        end else begin
            ax_val = $signed({1'b0, mag_clip});
        end
    end

    // radius check
    always_comb begin
        ax_cur  = ax_reg[axis_reg];
        ax_neg  = -ax_cur;
        ax_abs  = ax_cur[OUT_W-1] ? ax_neg[MAG_W-1:0] : ax_cur[MAG_W-1:0];
        rad2    = {1'b0, mag_reg} + {1'b0, sq_reg};
        in_dead = rad2 <= DEAD_R2;
    end

    // limits, centers, sums, count, axis index and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_AXIS; i++) begin
                lim_reg[i].lo <= MIN_RESET;
                lim_reg[i].hi <= MAX_RESET;
                center_reg[i] <= CENTER_RESET;
                sum_reg[i]    <= '0;
            end
            count_reg   <= '0;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid && cfg_index < CFG_NREG) begin
                if (cfg_index[0]) begin
                    lim_reg[cfg_index[AXIS_W:1]].hi <= cfg_data;
                end else begin
                    lim_reg[cfg_index[AXIS_W:1]].lo <= cfg_data;
                end
            end
            // calibration accumulate
            if (cmd.accum) begin
                for (int i = 0; i < N_AXIS; i++) begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(raw_ax[i]);
                end
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.store_center) begin
                center_reg[axis_reg] <= cal_prod[RECIP_SH +: RAW_W];
            end
            // axis sequencing
            if (cmd.axis_clr) begin
                axis_reg <= '0;
            end else if (cmd.axis_inc) begin
                axis_reg <= axis_reg + 1'b1;
            end
            // result register
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_frame) begin
            frame_reg <= s_data;
        end
        if (cmd.div_load_scl) begin
            zero_reg <= zero_now;
            sat_reg  <= sat_now;
            neg_reg  <= neg_now;
        end
        if (cmd.store_axis) begin
            ax_reg[axis_reg] <= ax_val;
        end
        if (cmd.sq) begin
            sq_reg <= SQ_W'(ax_abs) * SQ_W'(ax_abs);
        end
        if (cmd.acc) begin
            if (!axis_reg[0]) begin
                mag_reg <= sq_reg;
            end else if (in_dead) begin
                for (int i = 0; i < N_AXIS; i++) begin
                    if (i[1] == axis_reg[1]) begin
                        ax_reg[i] <= '0;
                    end
                end
            end
        end
        if (cmd.emit) begin
            m_data_reg.left_x  <= ax_reg[0];
            m_data_reg.left_y  <= ax_reg[1];
            m_data_reg.right_x <= ax_reg[2];
            m_data_reg.right_y <= ax_reg[3];
        end
    end

    // status back to the controller
    always_comb begin
        sts.frame_ok    = frame_reg.start_byte == FRAME_HEAD &&
                          frame_reg.end_byte == FRAME_TAIL;
        sts.calibrating = count_reg < CNT_W'(CAL_FRAMES);
        sts.cal_last    = count_reg == CNT_W'(CAL_FRAMES - 1);
        sts.div_done    = div_done;
        sts.axis_last   = axis_reg == AXIS_W'(N_AXIS - 1);
        sts.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/dscd_ctrl.sv]
// ----------------------------------------------------------------------------
// dscd_ctrl
// sequencer: frame check, calibration average, per axis scaling, radius
// check and hand-off to the result register
// ----------------------------------------------------------------------------
module dscd_ctrl
    import dscd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_frame = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.axis_clr = 1'b1;
                if (!sts.frame_ok) begin
                    state_next = S_IDLE;
                end else if (sts.calibrating) begin
                    cmd.accum  = 1'b1;
                    state_next = sts.cal_last ? S_CAL_STORE : S_IDLE;
                end else begin
                    state_next = S_SCL_LOAD;
                end
            end
            S_CAL_STORE: begin
                cmd.store_center = 1'b1;
                if (sts.axis_last) begin
                    cmd.axis_clr = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    cmd.axis_inc = 1'b1;
                end
            end
            S_SCL_LOAD: begin
                cmd.div_load_scl = 1'b1;
                state_next       = S_SCL_DIV;
            end
            S_SCL_DIV: begin
                if (sts.div_done) begin
                    state_next = S_SCL_STORE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_SCL_STORE: begin
                cmd.store_axis = 1'b1;
                if (sts.axis_last) begin
                    cmd.axis_clr = 1'b1;
                    state_next   = S_SQ;
                end else begin
                    cmd.axis_inc = 1'b1;
                    state_next   = S_SCL_LOAD;
                end
            end
            S_SQ: begin
                cmd.sq     = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (sts.axis_last) begin
                    cmd.axis_clr = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.axis_inc = 1'b1;
                    state_next   = S_SQ;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/dscd_checker.sv]
// ----------------------------------------------------------------------------
// dscd_checker
// port level checks for the stick calibration block, bound to the top level
// ----------------------------------------------------------------------------
module dscd_checker
    import dscd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input out_word_t            m_data
);

    localparam logic signed [OUT_W-1:0] FULL_POS  = 16'sd32760;
    localparam logic signed [OUT_W-1:0] FULL_NEG  = -16'sd32760;
    localparam logic signed [OUT_W-1:0] INNER_POS = 16'sd2316;
    localparam logic signed [OUT_W-1:0] INNER_NEG = -16'sd2316;

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one frame at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a frame is in work");

    // every axis stays within full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.left_x >= FULL_NEG && m_data.left_x <= FULL_POS &&
                    m_data.left_y >= FULL_NEG && m_data.left_y <= FULL_POS &&
                    m_data.right_x >= FULL_NEG && m_data.right_x <= FULL_POS &&
                    m_data.right_y >= FULL_NEG && m_data.right_y <= FULL_POS)
        else $error("axis beyond full scale");

    // a left stick well inside the deadzone radius reads zero on both axes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.left_x >= INNER_NEG && m_data.left_x <= INNER_POS &&
        m_data.left_y >= INNER_NEG && m_data.left_y <= INNER_POS
        |-> m_data.left_x == '0 && m_data.left_y == '0)
        else $error("left stick inside deadzone not zeroed");

    // same for the right stick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.right_x >= INNER_NEG && m_data.right_x <= INNER_POS &&
        m_data.right_y >= INNER_NEG && m_data.right_y <= INNER_POS
        |-> m_data.right_x == '0 && m_data.right_y == '0)
        else $error("right stick inside deadzone not zeroed");

endmodule

bind dual_stick_calibrate_deadzone_top dscd_checker u_dscd_checker (.*);
